// ----- src/ldtw_pkg.sv -----
package ldtw_pkg;

	localparam logic [1:0] OP_CMD   = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_ADDR  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] HOLD_ONE   = 2'd0;
	localparam logic [1:0] HOLD_SHORT = 2'd1;
	localparam logic [1:0] HOLD_HALF  = 2'd2;
	localparam logic [1:0] HOLD_GAP   = 2'd3;

	localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
	localparam logic [7:0] ADDR_BASE      = 8'hC0;
	localparam logic [7:0] BIT_ONE        = 8'h01;

	localparam logic [1:0] REG_SHORT_HOLD = 2'd0;
	localparam logic [1:0] REG_HALF_BIT   = 2'd1;
	localparam logic [1:0] REG_STOP_GAP   = 2'd2;

	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] column;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic       clock_level;
		logic       data_level;
		logic [1:0] hold_class;
		logic       last_step;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START0,
		ST_START1,
		ST_START2,
		ST_BIT_LO,
		ST_BIT_HI,
		ST_ACK,
		ST_STOP0,
		ST_STOP1
	} state_t;

	typedef enum logic [1:0] {
		SEL_CMD,
		SEL_ADDR,
		SEL_DATA
	} byte_sel_t;

	typedef struct packed {
		logic       capture;
		logic       emit;
		logic       load;
		byte_sel_t  sel;
		logic       shift;
		logic       clk_lvl;
		logic       dio_bit;
		logic       dio_lvl;
		logic [1:0] hold;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic       out_free;
		logic       bit_last;
		logic [1:0] opcode;
	} status_t;

endpackage

// ----- src/ldtw_ctrl.sv -----
module ldtw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_opcode,
	output logic               in_ready,
	input  ldtw_pkg::status_t  st,
	output ldtw_pkg::cmd_t     cmd
);

	ldtw_pkg::state_t state_q, state_d;
	logic addr_frame_q, addr_frame_d;
	logic second_q, second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ldtw_pkg::ST_IDLE;
			addr_frame_q <= 1'b0;
			second_q     <= 1'b0;
		end else begin
			state_q      <= state_d;
			addr_frame_q <= addr_frame_d;
			second_q     <= second_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		addr_frame_d = addr_frame_q;
		second_d     = second_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.sel      = ldtw_pkg::SEL_CMD;
		case (state_q)
			ldtw_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					case (in_opcode)
						ldtw_pkg::OP_CMD, ldtw_pkg::OP_WRITE: begin
							state_d      = ldtw_pkg::ST_START0;
							addr_frame_d = 1'b0;
						end
						ldtw_pkg::OP_ADDR: begin
							state_d      = ldtw_pkg::ST_START0;
							addr_frame_d = 1'b1;
						end
						default: state_d = ldtw_pkg::ST_IDLE;
					endcase
				end
			end
			ldtw_pkg::ST_START0: begin
				cmd.emit    = st.out_free;
				cmd.clk_lvl = 1'b1;
				cmd.dio_lvl = 1'b1;
				cmd.hold    = ldtw_pkg::HOLD_SHORT;
				if (st.out_free) state_d = ldtw_pkg::ST_START1;
			end
			ldtw_pkg::ST_START1: begin
				cmd.emit    = st.out_free;
				cmd.clk_lvl = 1'b1;
				cmd.hold    = ldtw_pkg::HOLD_ONE;
				if (st.out_free) state_d = ldtw_pkg::ST_START2;
			end
			ldtw_pkg::ST_START2: begin
				cmd.emit = st.out_free;
				cmd.load = st.out_free;
				cmd.sel  = addr_frame_q ? ldtw_pkg::SEL_ADDR : ldtw_pkg::SEL_CMD;
				cmd.hold = ldtw_pkg::HOLD_ONE;
				if (st.out_free) begin
					state_d  = ldtw_pkg::ST_BIT_LO;
					second_d = 1'b0;
				end
			end
			ldtw_pkg::ST_BIT_LO: begin
				cmd.emit    = st.out_free;
				cmd.dio_bit = 1'b1;
				cmd.hold    = ldtw_pkg::HOLD_HALF;
				if (st.out_free) state_d = ldtw_pkg::ST_BIT_HI;
			end
			ldtw_pkg::ST_BIT_HI: begin
				cmd.emit    = st.out_free;
				cmd.shift   = st.out_free;
				cmd.clk_lvl = 1'b1;
				cmd.dio_bit = 1'b1;
				cmd.hold    = ldtw_pkg::HOLD_HALF;
				if (st.out_free) begin
					state_d = st.bit_last ? ldtw_pkg::ST_ACK : ldtw_pkg::ST_BIT_LO;
				end
			end
			ldtw_pkg::ST_ACK: begin
				cmd.emit = st.out_free;
				cmd.hold = ldtw_pkg::HOLD_ONE;
				cmd.sel  = ldtw_pkg::SEL_DATA;
				if (st.out_free) begin
					if (addr_frame_q && !second_q) begin
						cmd.load = 1'b1;
						second_d = 1'b1;
						state_d  = ldtw_pkg::ST_BIT_LO;
					end else begin
						state_d = ldtw_pkg::ST_STOP0;
					end
				end
			end
			ldtw_pkg::ST_STOP0: begin
				cmd.emit    = st.out_free;
				cmd.clk_lvl = 1'b1;
				cmd.hold    = ldtw_pkg::HOLD_SHORT;
				if (st.out_free) state_d = ldtw_pkg::ST_STOP1;
			end
			ldtw_pkg::ST_STOP1: begin
				cmd.emit    = st.out_free;
				cmd.clk_lvl = 1'b1;
				cmd.dio_lvl = 1'b1;
				cmd.hold    = ldtw_pkg::HOLD_GAP;
				cmd.last    = addr_frame_q || (st.opcode == ldtw_pkg::OP_CMD);
				if (st.out_free) begin
					if (!addr_frame_q && st.opcode == ldtw_pkg::OP_WRITE) begin
						addr_frame_d = 1'b1;
						state_d      = ldtw_pkg::ST_START0;
					end else begin
						state_d = ldtw_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = ldtw_pkg::ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.last |=> state_q == ldtw_pkg::ST_IDLE)
		else $error("request did not end after its final step");
	a_load_emits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> cmd.emit && st.out_free)
		else $error("byte loaded without a step beat");
	a_bit_loop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ldtw_pkg::ST_BIT_HI && cmd.emit && !st.bit_last
		|=> state_q == ldtw_pkg::ST_BIT_LO)
		else $error("bit loop left early");
`endif

endmodule

// ----- src/ldtw_datapath.sv -----
module ldtw_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ldtw_pkg::req_t                       in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output ldtw_pkg::rsp_t                       out_data,
	input  logic                                 cfg_we,
	input  logic [ldtw_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ldtw_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  ldtw_pkg::cmd_t                       cmd,
	output ldtw_pkg::status_t                    st
);

	ldtw_pkg::req_t req_q;
	logic [7:0]     shift_q;
	logic [2:0]     bit_cnt_q;
	logic [7:0]     next_byte;
	logic           out_valid_q;
	ldtw_pkg::rsp_t out_q;
	logic [15:0]    short_hold_q;
	logic [23:0]    half_bit_q;
	logic [23:0]    stop_gap_q;

	always_comb begin
		case (cmd.sel)
			ldtw_pkg::SEL_CMD:
				next_byte = (req_q.opcode == ldtw_pkg::OP_CMD) ? req_q.data_byte
				                                                : ldtw_pkg::CMD_FIXED_ADDR;
			ldtw_pkg::SEL_ADDR: next_byte = ldtw_pkg::ADDR_BASE | {4'b0000, req_q.column};
			ldtw_pkg::SEL_DATA: next_byte = req_q.data_byte;
			default:            next_byte = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= in_data;
		if (cmd.load) begin
			shift_q   <= next_byte;
			bit_cnt_q <= '0;
		end else if (cmd.shift) begin
			shift_q   <= shift_q >> 1;
			bit_cnt_q <= bit_cnt_q + 3'd1;
		end
		if (cmd.emit) begin
			out_q.clock_level <= cmd.clk_lvl;
			out_q.data_level  <= cmd.dio_bit ? (shift_q[0] & ldtw_pkg::BIT_ONE[0]) : cmd.dio_lvl;
			out_q.hold_class  <= cmd.hold;
			out_q.last_step   <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_hold_q <= 16'd50;
			half_bit_q   <= 24'd25000;
			stop_gap_q   <= 24'd5000;
		end else if (cfg_we) begin
			case (cfg_index)
				ldtw_pkg::REG_SHORT_HOLD: short_hold_q <= cfg_wdata[15:0];
				ldtw_pkg::REG_HALF_BIT:   half_bit_q   <= cfg_wdata;
				ldtw_pkg::REG_STOP_GAP:   stop_gap_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign st.out_free = !out_valid_q || out_ready;
	assign st.bit_last = (bit_cnt_q == 3'd7);
	assign st.opcode   = req_q.opcode;

`ifndef SYNTHESIS
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("step beat not presented");
	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift && !cmd.load |=> bit_cnt_q == $past(bit_cnt_q) + 3'd1)
		else $error("bit counter out of step with shifter");
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == ldtw_pkg::REG_HALF_BIT
		|=> half_bit_q == $past(cfg_wdata) && $stable(short_hold_q) && $stable(stop_gap_q))
		else $error("half bit register write lost or spread");
`endif

endmodule

// ----- src/led_driver_two_wire_write_serializer.sv -----
// Two-wire LED driver write serializer.
// Input channel (in_valid/in_ready, in_data): one request per beat, opcode 0
// sends a command frame, 1 the fixed-address command then address and data,
// 2 only the address-and-data frame; opcode 3 is dropped without output.
// Output channel (out_valid/out_ready, out_data): one pin step per beat, the
// clock and data levels to drive, a hold class for the pin timer, and a
// last-step flag on the final step of the request.
// Requests yield 22, 61 or 39 steps. One step leaves per cycle while the
// receiver takes them, through a single output register, and the next
// request is accepted only once the final step is in the output register.
// A stalled receiver holds the current step and freezes the sequencer.
// Configuration (cfg_we, cfg_index, cfg_wdata) sets the hold time registers
// with no wait; write them while no request is in progress.
// Reset clears the sequencer and the output valid flag and restores the
// hold registers to 50, 25000 and 5000.
module led_driver_two_wire_write_serializer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ldtw_pkg::req_t                    in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ldtw_pkg::rsp_t                    out_data,
	input  logic                              cfg_we,
	input  logic [ldtw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ldtw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	ldtw_pkg::cmd_t    cmd;
	ldtw_pkg::status_t st;

	ldtw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_data.opcode),
		.in_ready  (in_ready),
		.st        (st),
		.cmd       (cmd)
	);

	ldtw_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
